/* rtl/sjfq_pkg.sv */
// ----------------------------------------------------------------------------
// sjfq_pkg: shared definitions for the shortest-job-first queue
// Capacity, derived widths, the stored entry layout, the request and status
// codes, and the memory access bundle passed from control to storage.
// ----------------------------------------------------------------------------
package sjfq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 16;
    localparam int ID_W     = 16;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DRAIN  = 1'b1;

    localparam logic [1:0] ST_TASK  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

/* rtl/sjfq_mem.sv */
// ----------------------------------------------------------------------------
// sjfq_mem: entry storage for the queue
// One write port and one read port; the read data is registered, so it is
// valid in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module sjfq_mem (
    input  logic              clk,
    input  sjfq_pkg::mem_req_t req,
    output sjfq_pkg::entry_t  rdata
);

    sjfq_pkg::entry_t mem_array [sjfq_pkg::CAPACITY];
    sjfq_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_array[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem_array[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sjfq_ctrl.sv */
// ----------------------------------------------------------------------------
// sjfq_ctrl: sequencer for insert and drain requests
// Inserts walk from the tail toward the head, moving each larger-or-equal
// entry up one slot until the new entry's place is found. Drains read the
// store in order, one entry per cycle, and register each result.
// ----------------------------------------------------------------------------
module sjfq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  action,
    input  logic [15:0]           task_id,
    input  logic [15:0]           task_cycles,
    output sjfq_pkg::mem_req_t    mem_req,
    input  sjfq_pkg::entry_t      mem_rdata,
    output logic                  result_valid,
    output logic [15:0]           out_id,
    output logic [15:0]           out_cycles,
    output logic [1:0]            status,
    output logic                  last
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_INS_RD  = 4'b0010,
        S_INS_CMP = 4'b0100,
        S_DRAIN   = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [sjfq_pkg::CNT_W-1:0]   entry_count_reg, entry_count_next;
    logic [sjfq_pkg::IDX_W-1:0]   pos_reg, pos_next;
    logic [sjfq_pkg::IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    sjfq_pkg::entry_t             new_reg, new_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic                         last_pend_reg, last_pend_next;
    logic                         valid_reg, valid_next;
    logic [15:0]                  out_id_reg, out_id_next;
    logic [15:0]                  out_cycles_reg, out_cycles_next;
    logic [1:0]                   status_reg, status_next;
    logic                         last_reg, last_next;
    logic                         accept;
    logic                         is_full;
    logic                         drain_last;

    assign busy       = (state_reg != S_IDLE) || rd_pend_reg;
    assign accept     = start && !busy;
    assign is_full    = (entry_count_reg == sjfq_pkg::CNT_W'(sjfq_pkg::CAPACITY));
    assign drain_last = ((sjfq_pkg::CNT_W'(rd_ptr_reg) + 1'b1) == entry_count_reg);

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        pos_next         = pos_reg;
        rd_ptr_next      = rd_ptr_reg;
        new_next         = new_reg;
        rd_pend_next     = 1'b0;
        last_pend_next   = last_pend_reg;
        valid_next       = 1'b0;
        out_id_next      = out_id_reg;
        out_cycles_next  = out_cycles_reg;
        status_next      = status_reg;
        last_next        = last_reg;
        mem_req          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == sjfq_pkg::ACT_INSERT)
                    begin
                        if (is_full)
                        begin
                            valid_next      = 1'b1;
                            out_id_next     = '0;
                            out_cycles_next = '0;
                            status_next     = sjfq_pkg::ST_FULL;
                            last_next       = 1'b1;
                        end
                        else
                        begin
                            new_next.key = task_cycles;
                            new_next.id  = task_id;
                            pos_next     = sjfq_pkg::IDX_W'(entry_count_reg);
                            state_next   = S_INS_RD;
                        end
                    end
                    else if (entry_count_reg == '0)
                    begin
                        valid_next      = 1'b1;
                        out_id_next     = '0;
                        out_cycles_next = '0;
                        status_next     = sjfq_pkg::ST_EMPTY;
                        last_next       = 1'b1;
                    end
                    else
                    begin
                        rd_ptr_next = '0;
                        state_next  = S_DRAIN;
                    end
                end
            end

            S_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_req.we       = 1'b1;
                    mem_req.waddr    = pos_reg;
                    mem_req.wdata    = new_reg;
                    entry_count_next = entry_count_reg + 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = pos_reg - 1'b1;
                    state_next    = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                if (new_reg.key > mem_rdata.key)
                begin
                    mem_req.wdata    = new_reg;
                    entry_count_next = entry_count_reg + 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    mem_req.wdata = mem_rdata;
                    pos_next      = pos_reg - 1'b1;
                    state_next    = S_INS_RD;
                end
            end

            S_DRAIN:
            begin
                mem_req.re     = 1'b1;
                mem_req.raddr  = rd_ptr_reg;
                rd_pend_next   = 1'b1;
                last_pend_next = drain_last;
                if (drain_last)
                begin
                    entry_count_next = '0;
                    state_next       = S_IDLE;
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Read data from the drain sweep is captured into the result register the cycle after it arrives.
        if (rd_pend_reg)
        begin
            valid_next      = 1'b1;
            out_id_next     = mem_rdata.id;
            out_cycles_next = mem_rdata.key;
            status_next     = sjfq_pkg::ST_TASK;
            last_next       = last_pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            rd_pend_reg     <= 1'b0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            rd_pend_reg     <= rd_pend_next;
            valid_reg       <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        rd_ptr_reg     <= rd_ptr_next;
        new_reg        <= new_next;
        last_pend_reg  <= last_pend_next;
        out_id_reg     <= out_id_next;
        out_cycles_reg <= out_cycles_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
    end

    assign result_valid = valid_reg;
    assign out_id       = out_id_reg;
    assign out_cycles   = out_cycles_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= sjfq_pkg::CNT_W'(sjfq_pkg::CAPACITY))
        else $error("entry count exceeds capacity");

    a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> !mem_req.we)
        else $error("store written during a drain");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (sjfq_pkg::CNT_W'(mem_req.waddr) <= entry_count_reg))
        else $error("write beyond the filled part of the store");

    a_empty_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == sjfq_pkg::ACT_DRAIN) && (entry_count_reg == '0))
        |=> (result_valid && (status == sjfq_pkg::ST_EMPTY) && last))
        else $error("drain of an empty queue did not report empty");

    a_drain_result: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |=> (result_valid && (status == sjfq_pkg::ST_TASK)))
        else $error("drained entry not delivered");

endmodule

/* rtl/shortest_job_first_queue.sv */
// ----------------------------------------------------------------------------
// shortest_job_first_queue: bounded task queue sorted by cycle count
// An insert for N stored tasks does one memory read and one write-back per
// entry that has to move up a slot, then writes the new entry into its gap.
// A drain of N tasks passes each entry through the memory read register and
// the result register, one result per cycle, bounded by the single memory read port.
// Refused inserts and empty drains report in the cycle after the request.
// Reset clears the entry count and control state; no clearing pass is run.
// ----------------------------------------------------------------------------
//
// The store holds up to CAPACITY entries, each a cycle count and a task id,
// kept in ascending order of cycle count from address 0 upward. An insert
// request starts at the tail and moves every entry whose count is not
// smaller than the new one up by one slot, then writes the new entry into
// the gap; equal counts therefore leave the newest task ahead of older ones.
// Each step reads one entry and writes it back in the following cycle, so reads and
// writes of the same address never overlap.
//
// A drain request sweeps the store from the head, one read per cycle, and
// presents every entry with status "task" on the result ports, flagging the
// final one with last. The queue is empty afterward. Results are strobed by
// result_valid for one cycle each and cannot be held off by the receiver.
// busy stays high until the final read of a drain has been delivered to the
// output register, so a new request may arrive while that result is shown.
module shortest_job_first_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [15:0] task_id,
    input  logic [15:0] task_cycles,
    output logic        result_valid,
    output logic [15:0] out_id,
    output logic [15:0] out_cycles,
    output logic [1:0]  status,
    output logic        last
);

    sjfq_pkg::mem_req_t mem_req;
    sjfq_pkg::entry_t   mem_rdata;

    // Entry storage: one write and one registered read per cycle.
    sjfq_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // Request sequencing, entry count and the result register.
    sjfq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .task_id      (task_id),
        .task_cycles  (task_cycles),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata),
        .result_valid (result_valid),
        .out_id       (out_id),
        .out_cycles   (out_cycles),
        .status       (status),
        .last         (last)
    );

endmodule
